[src/lsmt_pkg.sv]
`default_nettype none
package lsmt_pkg;

	// line timing, in clock cycles
	localparam logic [9:0] LINE_LEN = 10'd456;
	localparam logic [9:0] SCAN_END = 10'd80;
	localparam logic [9:0] DRAW_END = 10'd252;

	// line numbers
	localparam logic [7:0] VBLANK_LINE = 8'd144;
	localparam logic [7:0] LAST_LINE   = 8'd153;

	// lcd mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	// stat interrupt enable bit positions
	localparam int IRQ_HBLANK = 0;
	localparam int IRQ_VBLANK = 1;
	localparam int IRQ_SCAN   = 2;
	localparam int IRQ_MATCH  = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_IRQ_ENABLES = 2'd2;

	typedef struct packed {
		logic       display_enable;
		logic [7:0] line_compare;
		logic [3:0] stat_irq_enables;
	} cfg_t;

	typedef struct packed {
		logic [9:0] line_cycles;
		logic [7:0] line_number;
		logic [1:0] mode_bits;
		logic       match_flag;
	} timer_state_t;

	typedef struct packed {
		logic [7:0] current_line;
		logic [1:0] lcd_mode;
		logic       coincidence;
		logic       vblank_request;
		logic       stat_request;
		logic       frame_done;
		logic       scan_start;
		logic       draw_start;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       stat;
		logic       scan;
		logic       draw;
	} mode_entry_t;

	// mode change with its side effects; no effect when the mode is unchanged
	function automatic mode_entry_t enter_mode(input logic [1:0] cur, input logic [1:0] m,
		input logic [3:0] en);
		mode_entry_t e;
		e.mode = m;
		e.stat = 1'b0;
		e.scan = 1'b0;
		e.draw = 1'b0;
		if (cur != m) begin
			case (m)
				MODE_HBLANK: e.stat = en[IRQ_HBLANK];
				MODE_VBLANK: e.stat = en[IRQ_VBLANK];
				MODE_SCAN: begin
					e.stat = en[IRQ_SCAN];
					e.scan = 1'b1;
				end
				MODE_DRAW: e.draw = 1'b1;
				default: e.stat = 1'b0;
			endcase
		end
		return e;
	endfunction

endpackage
`default_nettype wire

[src/lsmt_if.sv]
`default_nettype none
// tick input channel
interface lsmt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] tick_cycles;

	modport source (output valid, output tick_cycles, input ready);
	modport sink (input valid, input tick_cycles, output ready);
endinterface

// timing status output channel
interface lsmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] current_line;
	logic [1:0] lcd_mode;
	logic       coincidence;
	logic       vblank_request;
	logic       stat_request;
	logic       frame_done;
	logic       scan_start;
	logic       draw_start;

	modport source (output valid, output current_line, output lcd_mode, output coincidence,
		output vblank_request, output stat_request, output frame_done, output scan_start,
		output draw_start, input ready);
	modport sink (input valid, input current_line, input lcd_mode, input coincidence,
		input vblank_request, input stat_request, input frame_done, input scan_start,
		input draw_start, output ready);
endinterface
`default_nettype wire

[src/lsmt_cfg.sv]
`default_nettype none
module lsmt_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lsmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lsmt_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lsmt_pkg::cfg_t                         cfg
);

	lsmt_pkg::cfg_t cfg_q;

	// register file, reset to display on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_enable   <= 1'b1;
			cfg_q.line_compare     <= 8'd0;
			cfg_q.stat_irq_enables <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsmt_pkg::REG_DISPLAY_ENABLE:   cfg_q.display_enable <= cfg_data[0];
				lsmt_pkg::REG_LINE_COMPARE:     cfg_q.line_compare <= cfg_data[7:0];
				lsmt_pkg::REG_STAT_IRQ_ENABLES: cfg_q.stat_irq_enables <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[src/lsmt_step.sv]
`default_nettype none
module lsmt_step (
	input  wire lsmt_pkg::cfg_t         cfg,
	input  wire lsmt_pkg::timer_state_t cur,
	input  wire logic [7:0]             tick_cycles,
	output lsmt_pkg::timer_state_t      nxt,
	output lsmt_pkg::result_t           res
);

	logic [9:0]              sum;
	logic                    line_end;
	logic [7:0]              line_inc;
	logic [7:0]              line_new;
	logic                    win_hit;
	logic [1:0]              win_mode;
	logic                    match_new;
	lsmt_pkg::mode_entry_t   e_off;
	lsmt_pkg::mode_entry_t   e_win;
	lsmt_pkg::mode_entry_t   e_vbl;

	// counter advance and line end detect
	assign sum      = cur.line_cycles + {2'b00, tick_cycles};
	assign line_end = (sum >= lsmt_pkg::LINE_LEN);
	assign line_inc = cur.line_number + 8'd1;
	assign line_new = (line_inc > lsmt_pkg::LAST_LINE) ? 8'd0 : line_inc;
	assign match_new = (line_new == cfg.line_compare);

	// mode window the tick lands in
	always_comb begin
		win_hit  = 1'b1;
		win_mode = lsmt_pkg::MODE_HBLANK;
		if (cur.line_number >= lsmt_pkg::VBLANK_LINE) begin
			win_mode = lsmt_pkg::MODE_VBLANK;
		end else if (sum < lsmt_pkg::SCAN_END) begin
			win_mode = lsmt_pkg::MODE_SCAN;
		end else if (sum < lsmt_pkg::DRAW_END) begin
			win_mode = lsmt_pkg::MODE_DRAW;
		end else if (!line_end) begin
			win_mode = lsmt_pkg::MODE_HBLANK;
		end else begin
			win_hit = 1'b0;
		end
	end

	// window entry, then forced vblank entry at line 144
	always_comb begin
		e_off = lsmt_pkg::enter_mode(cur.mode_bits, lsmt_pkg::MODE_HBLANK, cfg.stat_irq_enables);
		if (win_hit) begin
			e_win = lsmt_pkg::enter_mode(cur.mode_bits, win_mode, cfg.stat_irq_enables);
		end else begin
			e_win = '{mode: cur.mode_bits, stat: 1'b0, scan: 1'b0, draw: 1'b0};
		end
		if (line_end && (line_inc == lsmt_pkg::VBLANK_LINE)) begin
			e_vbl = lsmt_pkg::enter_mode(e_win.mode, lsmt_pkg::MODE_VBLANK,
				cfg.stat_irq_enables);
		end else begin
			e_vbl = '{mode: e_win.mode, stat: 1'b0, scan: 1'b0, draw: 1'b0};
		end
	end

	// next state and result
	always_comb begin
		if (!cfg.display_enable) begin
			nxt.line_cycles = 10'd0;
			nxt.line_number = 8'd0;
			nxt.mode_bits   = e_off.mode;
			nxt.match_flag  = cur.match_flag;
			res.vblank_request = 1'b0;
			res.frame_done     = 1'b0;
			res.stat_request   = e_off.stat;
			res.scan_start     = 1'b0;
			res.draw_start     = 1'b0;
		end else begin
			nxt.line_cycles = line_end ? (sum - lsmt_pkg::LINE_LEN) : sum;
			nxt.line_number = line_end ? line_new : cur.line_number;
			nxt.mode_bits   = e_vbl.mode;
			nxt.match_flag  = line_end ? match_new : cur.match_flag;
			res.vblank_request = line_end && (line_inc == lsmt_pkg::VBLANK_LINE);
			res.frame_done     = res.vblank_request;
			res.stat_request   = e_win.stat | e_vbl.stat
				| (line_end & match_new & cfg.stat_irq_enables[lsmt_pkg::IRQ_MATCH]);
			res.scan_start     = e_win.scan | e_vbl.scan;
			res.draw_start     = e_win.draw | e_vbl.draw;
		end
		res.current_line = nxt.line_number;
		res.lcd_mode     = nxt.mode_bits;
		res.coincidence  = nxt.match_flag;
	end

endmodule
`default_nettype wire

[src/lcd_scanline_mode_timer_unit.sv]
`default_nettype none
// LCD scanline mode timer. Each transfer on tick carries a cycle count; the unit
// advances a line counter that wraps at 456, steps the line 0..153, tracks the LCD mode
// (oam scan, pixel transfer, hblank, vblank) and the line-compare coincidence flag,
// and returns one status item per tick with the vblank, stat, frame-done, scan-start
// and draw-start pulses. One tick is accepted every cycle while status is not stalled;
// a tick is held in the input register and its status then in the status register.
// A stalled status holds the next tick in the input register and then blocks tick.
// The rate is set by the line/mode state update, a combinational add and compare
// loop into the state register. Configuration is to be written through
// cfg_we/cfg_index/cfg_data while idle; the unit itself does not enforce this.
module lcd_scanline_mode_timer_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lsmt_in_if.sink                              tick,
	lsmt_out_if.source                           status,
	input  wire logic                            cfg_we,
	input  wire logic [lsmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsmt_pkg::CFG_DATA_W-1:0] cfg_data
);

	lsmt_pkg::cfg_t         cfg;
	lsmt_pkg::timer_state_t state_q;
	lsmt_pkg::timer_state_t state_nxt;
	lsmt_pkg::result_t      res_nxt;
	lsmt_pkg::result_t      res_s2;
	logic                   valid_s1;
	logic [7:0]             tick_s1;
	logic                   valid_s2;
	logic                   adv;
	logic                   tick_ready;

	lsmt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsmt_step u_step (
		.cfg         (cfg),
		.cur         (state_q),
		.tick_cycles (tick_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// flow control: stage 1 moves when the status register is free or drains
	assign adv        = valid_s1 && (!valid_s2 || status.ready);
	assign tick_ready = !valid_s1 || adv;
	assign tick.ready = tick_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ready && tick.valid) begin
			tick_s1 <= tick.tick_cycles;
		end
	end

	// timing state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.line_cycles <= 10'd0;
			state_q.line_number <= 8'd0;
			state_q.mode_bits   <= lsmt_pkg::MODE_VBLANK;
			state_q.match_flag  <= 1'b1;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (status.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign status.valid          = valid_s2;
	assign status.current_line   = res_s2.current_line;
	assign status.lcd_mode       = res_s2.lcd_mode;
	assign status.coincidence    = res_s2.coincidence;
	assign status.vblank_request = res_s2.vblank_request;
	assign status.stat_request   = res_s2.stat_request;
	assign status.frame_done     = res_s2.frame_done;
	assign status.scan_start     = res_s2.scan_start;
	assign status.draw_start     = res_s2.draw_start;

	// counter always stays inside one line
	a_cycles_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_cycles < lsmt_pkg::LINE_LEN)
		else $error("line cycle counter out of range");

	// line number never passes the last line
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_number <= lsmt_pkg::LAST_LINE)
		else $error("line number out of range");

	// frame done only on entry to line 144 in vblank
	a_frame_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_done |-> res_s2.current_line == lsmt_pkg::VBLANK_LINE
		&& res_s2.lcd_mode == lsmt_pkg::MODE_VBLANK && res_s2.vblank_request)
		else $error("frame done outside vblank entry");

	// a tick that advances leaves a status item the next cycle
	a_adv_status: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("status item lost");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
module testbench;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_MAX = 10;
	// index with no register behind it, writes are dropped
	localparam logic [lsmt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lsmt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lsmt_pkg::CFG_DATA_W-1:0] cfg_data;

	lsmt_in_if tick_if();
	lsmt_out_if status_if();

	lcd_scanline_mode_timer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_if),
		.status(status_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ticks waiting to be sent and status items waiting to arrive
	logic [7:0] pending_ticks[$];
	lsmt_pkg::result_t expected_status[$];
	lsmt_pkg::result_t want_status;

	int idle_odds;
	int send_gap;
	int recv_stall;
	int mismatch_count;
	int status_count;
	int cycle_count;

	// timer state and register copies for prediction
	logic [9:0] pred_cycles;
	logic [7:0] pred_line;
	logic [1:0] pred_mode;
	logic       pred_match;
	logic       cfg_display;
	logic [7:0] cfg_lyc;
	logic [3:0] cfg_irq_en;
	logic       pend_stat;
	logic       pend_scan;
	logic       pend_draw;

	// mode change and the pulses it raises; nothing happens if the mode is unchanged
	function automatic void switch_mode(input logic [1:0] next_mode);
		if (pred_mode != next_mode) begin
			case (next_mode)
				lsmt_pkg::MODE_HBLANK:
					if (cfg_irq_en[lsmt_pkg::IRQ_HBLANK]) pend_stat = 1'b1;
				lsmt_pkg::MODE_VBLANK:
					if (cfg_irq_en[lsmt_pkg::IRQ_VBLANK]) pend_stat = 1'b1;
				lsmt_pkg::MODE_SCAN: begin
					if (cfg_irq_en[lsmt_pkg::IRQ_SCAN]) pend_stat = 1'b1;
					pend_scan = 1'b1;
				end
				default: pend_draw = 1'b1;
			endcase
			pred_mode = next_mode;
		end
	endfunction

	// advance the line timer by one tick and build the status it returns
	function automatic lsmt_pkg::result_t predict_status(input logic [7:0] cycles);
		lsmt_pkg::result_t r;
		r = '0;
		pend_stat = 1'b0;
		pend_scan = 1'b0;
		pend_draw = 1'b0;
		if (!cfg_display) begin
			pred_line = 8'd0;
			switch_mode(lsmt_pkg::MODE_HBLANK);
			pend_scan = 1'b0;
			pend_draw = 1'b0;
			pred_cycles = 10'd0;
		end else begin
			pred_cycles = pred_cycles + {2'b00, cycles};
			// window write, skipped on a visible line that has run past its end
			if (pred_line >= lsmt_pkg::VBLANK_LINE)
				switch_mode(lsmt_pkg::MODE_VBLANK);
			else if (pred_cycles < lsmt_pkg::SCAN_END)
				switch_mode(lsmt_pkg::MODE_SCAN);
			else if (pred_cycles < lsmt_pkg::DRAW_END)
				switch_mode(lsmt_pkg::MODE_DRAW);
			else if (pred_cycles < lsmt_pkg::LINE_LEN)
				switch_mode(lsmt_pkg::MODE_HBLANK);
			// line end
			if (pred_cycles >= lsmt_pkg::LINE_LEN) begin
				pred_cycles = pred_cycles - lsmt_pkg::LINE_LEN;
				pred_line = pred_line + 8'd1;
				if (pred_line == lsmt_pkg::VBLANK_LINE) begin
					switch_mode(lsmt_pkg::MODE_VBLANK);
					r.vblank_request = 1'b1;
					r.frame_done = 1'b1;
				end
				if (pred_line > lsmt_pkg::LAST_LINE)
					pred_line = 8'd0;
				pred_match = (pred_line == cfg_lyc);
				if (pred_match && cfg_irq_en[lsmt_pkg::IRQ_MATCH])
					pend_stat = 1'b1;
			end
		end
		r.current_line = pred_line;
		r.lcd_mode = pred_mode;
		r.coincidence = pred_match;
		r.stat_request = pend_stat;
		r.scan_start = pend_scan;
		r.draw_start = pend_draw;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("status %0d %s: expected %0d, got %0d", status_count, field, want, got);
		end
	endtask

	task automatic write_reg(input logic [lsmt_pkg::CFG_IDX_W-1:0] idx,
		input logic [lsmt_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			lsmt_pkg::REG_DISPLAY_ENABLE: cfg_display = data[0];
			lsmt_pkg::REG_LINE_COMPARE: cfg_lyc = data;
			lsmt_pkg::REG_STAT_IRQ_ENABLES: cfg_irq_en = data[3:0];
			default: ;
		endcase
	endtask

	// unused upper bits carry random filler
	task automatic set_config(input logic display_on, input logic [7:0] compare_line,
		input logic [3:0] irq_en);
		write_reg(REG_UNUSED, 8'($urandom));
		write_reg(lsmt_pkg::REG_DISPLAY_ENABLE, {7'($urandom), display_on});
		write_reg(lsmt_pkg::REG_LINE_COMPARE, compare_line);
		write_reg(lsmt_pkg::REG_STAT_IRQ_ENABLES, {4'($urandom), irq_en});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly long ticks so that many lines go by
	task automatic queue_random_ticks(input int count);
		logic [7:0] cycles;
		@(negedge clk);
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1: cycles = 8'($urandom_range(0, 255));
				2: cycles = 8'($urandom_range(0, 15));
				default: cycles = 8'($urandom_range(180, 255));
			endcase
			pending_ticks.push_back(cycles);
		end
	endtask

	// wait until every tick is sent and every status item is back
	task automatic wait_idle();
		@(negedge clk);
		while (pending_ticks.size() != 0 || tick_if.valid || expected_status.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// tick driver with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_if.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (tick_if.valid && tick_if.ready)
				expected_status.push_back(predict_status(tick_if.tick_cycles));
			if (!tick_if.valid || tick_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					tick_if.valid <= 1'b0;
				end else if (pending_ticks.size() != 0 && $urandom_range(0, 99) < idle_odds) begin
					send_gap = $urandom_range(1, 19) - 1;
					tick_if.valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick_if.valid <= 1'b1;
					tick_if.tick_cycles <= pending_ticks.pop_front();
				end else begin
					tick_if.valid <= 1'b0;
				end
			end
		end
	end

	// status monitor with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			status_if.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (status_if.valid && status_if.ready) begin
				if (expected_status.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("status %0d arrived with no tick outstanding", status_count);
				end else begin
					want_status = expected_status.pop_front();
					compare_field("current_line", status_if.current_line,
						want_status.current_line);
					compare_field("lcd_mode", 8'(status_if.lcd_mode),
						8'(want_status.lcd_mode));
					compare_field("coincidence", 8'(status_if.coincidence),
						8'(want_status.coincidence));
					compare_field("vblank_request", 8'(status_if.vblank_request),
						8'(want_status.vblank_request));
					compare_field("stat_request", 8'(status_if.stat_request),
						8'(want_status.stat_request));
					compare_field("frame_done", 8'(status_if.frame_done),
						8'(want_status.frame_done));
					compare_field("scan_start", 8'(status_if.scan_start),
						8'(want_status.scan_start));
					compare_field("draw_start", 8'(status_if.draw_start),
						8'(want_status.draw_start));
				end
				status_count++;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				status_if.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_odds) begin
				recv_stall = $urandom_range(1, 19) - 1;
				status_if.ready <= 1'b0;
			end else begin
				status_if.ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_if.valid = 1'b0;
		tick_if.tick_cycles = 8'd0;
		status_if.ready = 1'b0;
		idle_odds = 8;
		mismatch_count = 0;
		status_count = 0;
		cycle_count = 0;
		pred_cycles = 10'd0;
		pred_line = 8'd0;
		pred_mode = lsmt_pkg::MODE_VBLANK;
		pred_match = 1'b1;
		cfg_display = 1'b1;
		cfg_lyc = 8'd0;
		cfg_irq_en = 4'd0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// display off straight out of reset, leaving vblank with hblank enabled
		set_config(1'b0, 8'd0, 4'b0001);
		@(negedge clk);
		pending_ticks = '{8'd255, 8'd0, 8'd128};
		wait_idle();

		// one line walked window by window, then skipped windows and extremes
		set_config(1'b1, 8'd1, 4'hF);
		@(negedge clk);
		pending_ticks = '{8'd0, 8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd0, 8'd255,
			8'd255, 8'd128, 8'd255, 8'd0, 8'd255, 8'd255, 8'd200, 8'd1};
		wait_idle();

		// display off in the middle of a line
		set_config(1'b0, 8'd1, 4'hF);
		@(negedge clk);
		pending_ticks = '{8'd37, 8'd255};
		wait_idle();

		// long run of random ticks, registers changed between legs
		set_config(1'b1, 8'd255, 4'd0);
		queue_random_ticks(70);
		wait_idle();

		idle_odds = 0;
		set_config(1'b1, 8'd0, 4'($urandom));
		queue_random_ticks(70);
		wait_idle();

		idle_odds = 20;
		set_config(1'b1, lsmt_pkg::LAST_LINE, 4'($urandom));
		queue_random_ticks(70);
		wait_idle();

		idle_odds = 8;
		set_config(1'b1, lsmt_pkg::VBLANK_LINE, 4'hF);
		queue_random_ticks(70);
		wait_idle();

		set_config(1'b1, 8'($urandom_range(0, 153)), 4'($urandom));
		queue_random_ticks(70);
		wait_idle();

		// display off wherever the frame stands
		set_config(1'b0, 8'($urandom), 4'($urandom));
		queue_random_ticks(3);
		wait_idle();

		// closing leg with no idling
		idle_odds = 0;
		set_config(1'b1, 8'd0, 4'hF);
		queue_random_ticks(40);
		wait_idle();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
src/lsmt_pkg.sv
src/lsmt_if.sv
src/lsmt_cfg.sv
src/lsmt_step.sv
src/lcd_scanline_mode_timer_unit.sv
verif/testbench.sv
